### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VSRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VSRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vsrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrt_pkg
// Register indexes, fixed constants and control types of the vertex transform.
// ----------------------------------------------------------------------------
package vsrt_pkg;

  typedef enum logic [3:0] {
    REG_SCALE       = 4'd0,
    REG_ANGLES      = 4'd1,
    REG_ANCHOR_X    = 4'd2,
    REG_ANCHOR_Y    = 4'd3,
    REG_ANCHOR_Z    = 4'd4,
    REG_TRANSLATE_X = 4'd5,
    REG_TRANSLATE_Y = 4'd6,
    REG_TRANSLATE_Z = 4'd7
  } vsrt_reg_t;

  localparam int unsigned CFG_INDEX_BITS = 4;
  localparam int unsigned CFG_DATA_BITS  = 48;
  localparam logic [47:0] SCALE_RESET    = 48'h1000_1000_1000;

  // Quarter turn in radians, Q30.
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
  localparam logic [4:0]  N_TERMS     = 5'd18;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } vsrt_rot_ctl_t;

endpackage

### hdl/vsrt_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrt_trig
// Sine and cosine cache, filled by a sequencer that sums a Taylor series with
// a term multiplier and a reciprocal divider that corrects its estimate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vsrt_trig #(
  parameter int TRIG_BITS = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [47:0]                 angles,
  output logic                        busy,
  output logic signed [TRIG_BITS-1:0] cache_o [6]
);
  import vsrt_pkg::*;

  localparam int F = TRIG_BITS - 2;
  localparam logic [31:0] ROUND_HALF = 32'(1) << (29 - F);
  localparam int NREC = int'(N_TERMS) + 1;

  typedef logic [NREC-1:0][32:0] recip_tab_t;

  // Entry n holds floor(2^32 / n); the estimate it gives is low by at most one.
  function automatic recip_tab_t make_recips();
    recip_tab_t tab;
    tab = '0;
    for (int i = 1; i < NREC; i++) begin
      tab[i] = 33'((64'd1 << 32) / 64'(i));
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = make_recips();

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_MUL, S_DIV, S_ACC, S_FIN} state_t;

  state_t                      state_r;
  logic [1:0]                  k_r;
  logic [4:0]                  n_r;
  logic [30:0]                 t_r;
  logic [31:0]                 term_r;
  logic [31:0]                 num_r;
  logic [31:0]                 quo_r;
  logic signed [33:0]          s_r;
  logic signed [33:0]          c_r;
  logic [47:0]                 ang_r;
  logic signed [TRIG_BITS-1:0] cache_r [6];

  logic [15:0]                 cur_ang;
  logic [44:0]                 tprod;
  logic [62:0]                 mprod;
  logic [63:0]                 rprod;
  logic [36:0]                 qn;
  logic [36:0]                 rem;
  logic [31:0]                 quo_fix;
  logic signed [33:0]          term_s;
  logic signed [TRIG_BITS-1:0] rs;
  logic signed [TRIG_BITS-1:0] rc;
  logic signed [TRIG_BITS-1:0] sin_q;
  logic signed [TRIG_BITS-1:0] cos_q;

  function automatic logic signed [TRIG_BITS-1:0] round_trig(input logic signed [33:0] v);
    logic [30:0] cl;
    logic [31:0] sum;
    if (v < 0) begin
      cl = '0;
    end else if (v > 34'sd1073741824) begin
      cl = 31'd1073741824;
    end else begin
      cl = v[30:0];
    end
    sum = 32'(cl) + ROUND_HALF;
    return TRIG_BITS'(sum >> (30 - F));
  endfunction

  always_comb begin
    unique case (k_r)
      2'd0:    cur_ang = ang_r[15:0];
      2'd1:    cur_ang = ang_r[31:16];
      2'd2:    cur_ang = ang_r[47:32];
      default: cur_ang = '0;
    endcase
    tprod   = 45'(cur_ang[13:0]) * 45'(PI_HALF_Q30) + 45'd8192;
    mprod   = 63'(term_r) * 63'(t_r);
    rprod   = 64'(num_r) * 64'(RECIP[n_r]);
    qn      = 37'(quo_r) * 37'(n_r);
    rem     = 37'(num_r) - qn;
    quo_fix = (rem >= 37'(n_r)) ? quo_r + 32'd1 : quo_r;
    term_s  = ((n_r[1:0] == 2'd0) || (n_r[1:0] == 2'd1)) ? 34'(quo_fix) : -34'(quo_fix);
    rs      = round_trig(s_r);
    rc      = round_trig(c_r);
    unique case (cur_ang[15:14])
      2'd0: begin
        sin_q = rs;
        cos_q = rc;
      end
      2'd1: begin
        sin_q = rc;
        cos_q = -rs;
      end
      2'd2: begin
        sin_q = -rs;
        cos_q = -rc;
      end
      default: begin
        sin_q = -rc;
        cos_q = rs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      n_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        cache_r[2*i]   <= TRIG_BITS'(1) << F;
        cache_r[2*i+1] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            ang_r   <= angles;
            k_r     <= '0;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          t_r     <= tprod[44:14];
          term_r  <= 32'd1073741824;
          s_r     <= '0;
          c_r     <= 34'sd1073741824;
          n_r     <= 5'd1;
          state_r <= S_MUL;
        end
        S_MUL: begin
          num_r   <= mprod[61:30];
          state_r <= S_DIV;
        end
        S_DIV: begin
          quo_r   <= rprod[63:32];
          state_r <= S_ACC;
        end
        S_ACC: begin
          term_r <= quo_fix;
          if (n_r[0]) begin
            s_r <= s_r + term_s;
          end else begin
            c_r <= c_r + term_s;
          end
          if (n_r == N_TERMS) begin
            state_r <= S_FIN;
          end else begin
            n_r     <= n_r + 5'd1;
            state_r <= S_MUL;
          end
        end
        S_FIN: begin
          unique case (k_r)
            2'd0: begin
              cache_r[0] <= cos_q;
              cache_r[1] <= sin_q;
            end
            2'd1: begin
              cache_r[2] <= cos_q;
              cache_r[3] <= sin_q;
            end
            default: begin
              cache_r[4] <= cos_q;
              cache_r[5] <= sin_q;
            end
          endcase
          if (k_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_SETUP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy    = (state_r != S_IDLE);
  assign cache_o = cache_r;

  `VSRT_ASSERT_IMP(a_fin_after_last_term, state_r == S_FIN, n_r == N_TERMS, "fill ended early")
  `VSRT_ASSERT_IMP(a_angle_slot_range, state_r != S_IDLE, k_r != 2'd3, "angle slot out of range")

endmodule

### hdl/vsrt_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrt_rot
// One plane rotation in two stages: four products, then the rounded sums.
// ----------------------------------------------------------------------------
module vsrt_rot #(
  parameter int WV        = 40,
  parameter int TRIG_BITS = 18
) (
  input  logic                        clk,
  input  vsrt_pkg::vsrt_rot_ctl_t     ctl,
  input  logic signed [WV-1:0]        a,
  input  logic signed [WV-1:0]        b,
  input  logic signed [WV-1:0]        pass_i,
  input  logic signed [TRIG_BITS-1:0] c,
  input  logic signed [TRIG_BITS-1:0] s,
  output logic signed [WV-1:0]        o1,
  output logic signed [WV-1:0]        o2,
  output logic signed [WV-1:0]        pass_o
);
  import vsrt_pkg::*;

  localparam int F  = TRIG_BITS - 2;
  localparam int WP = WV + TRIG_BITS;
  localparam logic signed [WP:0] HALF = (WP+1)'(1) <<< (F - 1);

  logic signed [WP-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [WV-1:0] pass_a_r, pass_b_r, o1_r, o2_r;
  logic signed [WP:0]   sum1, sum2;

  always_comb begin
    sum1 = (WP+1)'(ac_r) - (WP+1)'(bs_r) + HALF;
    sum2 = (WP+1)'(as_r) + (WP+1)'(bc_r) + HALF;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      ac_r     <= WP'(a) * WP'(c);
      bs_r     <= WP'(b) * WP'(s);
      as_r     <= WP'(a) * WP'(s);
      bc_r     <= WP'(b) * WP'(c);
      pass_a_r <= pass_i;
    end
    if (ctl.sum_en) begin
      o1_r     <= WV'(sum1 >>> F);
      o2_r     <= WV'(sum2 >>> F);
      pass_b_r <= pass_a_r;
    end
  end

  assign o1     = o1_r;
  assign o2     = o2_r;
  assign pass_o = pass_b_r;

endmodule

### hdl/vertex_scale_rotate_translate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate
// Scales a vertex, rotates it about an anchor by X, Y then Z, and translates
// it, saturating the result to the coordinate range.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)        tuser
//  in_      slave      x, y, z                   -
//  out_     master     x, y, z                   saturated
//  cfg_     slave      index, data               -
//
// One transaction per cycle unless the output stalls; a result passes the scale,
// anchor, rotation and output registers. Writing the rotation angles refills the
// sine/cosine cache by a multiply, divide and accumulate step for each of the 18
// series terms of each angle; inputs and configuration are held off meanwhile.
// Reset is synchronous: unit scale, zero angles, anchors and translations.
// A stall at the output holds only the stages behind a full stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_scale_rotate_translate #(
  parameter int COORD_BITS = 32,
  parameter int TRIG_BITS  = 18
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // x, y, z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // x, y, z
  output logic [((3*COORD_BITS+7)/8)*8-1:0]        out_tdata,
  // saturated
  output logic                                     out_tuser,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [vsrt_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [vsrt_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
  import vsrt_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int WV    = C + 8;
  localparam int WPS   = C + 16;
  localparam int WR    = WV + 2;
  localparam int OUT_W = ((3*C+7)/8)*8;
  localparam int NST   = 9;
  localparam logic signed [WR-1:0] MAXV = WR'({(C-1){1'b1}});
  localparam logic signed [WR-1:0] MINV = ~MAXV;

  logic [47:0]          scale_r;
  logic signed [C-1:0]  anchor_r [3];
  logic signed [C-1:0]  trans_r  [3];

  logic                 trig_busy;
  logic signed [TRIG_BITS-1:0] cache [6];

  logic [NST:1]         v_r;
  logic [NST:1]         en;
  logic                 in_fire;
  logic                 cfg_fire;
  logic                 ang_wr;

  logic signed [C-1:0]   in_c [3];
  logic signed [WPS-1:0] p_r  [3];
  logic signed [WV-1:0]  v2_r [3];
  logic signed [WPS:0]   pr   [3];

  logic signed [WV-1:0] ny, nz, x0, nx, nz2, ny2, rx, ry, rz;
  vsrt_rot_ctl_t        ctl_x, ctl_y, ctl_z;

  logic signed [WR-1:0] rsum [3];
  logic signed [C-1:0]  res  [3];
  logic [2:0]           clamp;
  logic signed [C-1:0]  out_r [3];
  logic                 sat_r;
  logic [2:0]           out_at_bound;

  assign cfg_ready = !trig_busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign ang_wr    = cfg_fire && (cfg_index == REG_ANGLES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      for (int i = 0; i < 3; i++) begin
        anchor_r[i] <= '0;
        trans_r[i]  <= '0;
      end
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_SCALE:       scale_r     <= cfg_data[47:0];
        REG_ANCHOR_X:    anchor_r[0] <= cfg_data[C-1:0];
        REG_ANCHOR_Y:    anchor_r[1] <= cfg_data[C-1:0];
        REG_ANCHOR_Z:    anchor_r[2] <= cfg_data[C-1:0];
        REG_TRANSLATE_X: trans_r[0]  <= cfg_data[C-1:0];
        REG_TRANSLATE_Y: trans_r[1]  <= cfg_data[C-1:0];
        REG_TRANSLATE_Z: trans_r[2]  <= cfg_data[C-1:0];
        default: ;
      endcase
    end
  end

  vsrt_trig #(.TRIG_BITS(TRIG_BITS)) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ang_wr),
    .angles  (cfg_data[47:0]),
    .busy    (trig_busy),
    .cache_o (cache)
  );

  always_comb begin
    en[NST] = !v_r[NST] || out_tready;
    for (int i = NST - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_tready = en[1] && !trig_busy;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_fire;
      end
      for (int i = 2; i <= NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_c[k] = in_tdata[k*C +: C];
      pr[k]   = (WPS+1)'(p_r[k]) + (WPS+1)'(2048);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= WPS'(in_c[k]) * WPS'($signed(scale_r[16*k +: 16]));
      end
    end
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        v2_r[k] <= WV'(pr[k] >>> 12) - WV'(anchor_r[k]);
      end
    end
  end

  assign ctl_x = '{mul_en: en[3], sum_en: en[4]};
  assign ctl_y = '{mul_en: en[5], sum_en: en[6]};
  assign ctl_z = '{mul_en: en[7], sum_en: en[8]};

  vsrt_rot #(.WV(WV), .TRIG_BITS(TRIG_BITS)) u_rot_x (
    .clk    (clk),
    .ctl    (ctl_x),
    .a      (v2_r[1]),
    .b      (v2_r[2]),
    .pass_i (v2_r[0]),
    .c      (cache[0]),
    .s      (cache[1]),
    .o1     (ny),
    .o2     (nz),
    .pass_o (x0)
  );

  vsrt_rot #(.WV(WV), .TRIG_BITS(TRIG_BITS)) u_rot_y (
    .clk    (clk),
    .ctl    (ctl_y),
    .a      (nz),
    .b      (x0),
    .pass_i (ny),
    .c      (cache[2]),
    .s      (cache[3]),
    .o1     (nz2),
    .o2     (nx),
    .pass_o (ny2)
  );

  vsrt_rot #(.WV(WV), .TRIG_BITS(TRIG_BITS)) u_rot_z (
    .clk    (clk),
    .ctl    (ctl_z),
    .a      (nx),
    .b      (ny2),
    .pass_i (nz2),
    .c      (cache[4]),
    .s      (cache[5]),
    .o1     (rx),
    .o2     (ry),
    .pass_o (rz)
  );

  always_comb begin
    rsum[0] = WR'(rx) + WR'(anchor_r[0]) + WR'(trans_r[0]);
    rsum[1] = WR'(ry) + WR'(anchor_r[1]) + WR'(trans_r[1]);
    rsum[2] = WR'(rz) + WR'(anchor_r[2]) + WR'(trans_r[2]);
    for (int k = 0; k < 3; k++) begin
      if (rsum[k] > MAXV) begin
        res[k]   = MAXV[C-1:0];
        clamp[k] = 1'b1;
      end else if (rsum[k] < MINV) begin
        res[k]   = MINV[C-1:0];
        clamp[k] = 1'b1;
      end else begin
        res[k]   = rsum[k][C-1:0];
        clamp[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      for (int k = 0; k < 3; k++) begin
        out_r[k] <= res[k];
      end
      sat_r <= |clamp;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_at_bound[k] = (out_r[k] == MAXV[C-1:0]) || (out_r[k] == MINV[C-1:0]);
    end
  end

  assign out_tvalid = v_r[NST];
  assign out_tdata  = OUT_W'({out_r[2], out_r[1], out_r[0]});
  assign out_tuser  = sat_r;

  `VSRT_ASSERT_IMP(a_no_input_during_fill, trig_busy, !in_tready, "input taken during fill")
  `VSRT_ASSERT_NXT(a_fill_follows_angles, ang_wr, trig_busy, "no fill after angle write")
  `VSRT_ASSERT_IMP(a_sat_at_bound, out_tvalid && out_tuser, |out_at_bound, "saturated off bound")

endmodule
